// ----- rtl/core/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and helpers of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int CHUNKS       = 64;
	localparam int IDX_W        = $clog2(CHUNKS);
	localparam int CNT_W        = IDX_W + 1;
	localparam int OFF_W        = 20;
	localparam int LEN_W        = 21;
	localparam int NEED_W       = 22;
	localparam int PAGE_W       = 9;
	localparam int HEADER_BYTES = 12;
	localparam int HEAP_BYTES   = 1048576;
	localparam int PAGE_BYTES   = 4096;
	localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_UNKNOWN   = 2'd3;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [LEN_W-1:0] len;
		logic             fr;
	} entry_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_RD,
		OP_SCAN_NEXT,
		OP_ALLOC_HIT,
		OP_FREE_HIT,
		OP_UNKNOWN,
		OP_NEXT_RD,
		OP_MERGE_R,
		OP_MERGE_L,
		OP_FREE_FIN,
		OP_APPEND,
		OP_MOVE_RD,
		OP_MOVE_WR,
		OP_MOVE_END,
		OP_RESULT
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_NEXT_RD,
		S_NEXT_CHK,
		S_MERGE_L,
		S_FREE_FIN,
		S_APPEND,
		S_MOVE_RD,
		S_MOVE_WR,
		S_MOVE_END,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic             scan_more;
		logic             is_free;
		logic             hit;
		logic             split;
		logic             has_next;
		logic             move_more;
		logic [CNT_W-1:0] cnt;
	} sts_t;

	// pages needed to cover a byte count, rounded up
	function automatic logic [PAGE_W-1:0] pages_for(input logic [LEN_W-1:0] bytes);
		logic [LEN_W:0] s;
		s = {1'b0, bytes} + (LEN_W+1)'(PAGE_BYTES - 1);
		return PAGE_W'(s >> PAGE_SHIFT);
	endfunction

endpackage

// ----- rtl/core/ffha_if.sv -----
// ----------------------------------------------------------------------------
// ffha_if
// Request and response channels of the heap allocator.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [20:0] request_bytes;
	logic [19:0] free_offset;

	modport source(output valid, mode, request_bytes, free_offset, input ready);
	modport sink(input valid, mode, request_bytes, free_offset, output ready);
endinterface

interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [19:0] payload_offset;
	logic [1:0]  status;
	logic [8:0]  mapped_pages;

	modport source(output valid, payload_offset, status, mapped_pages, input ready);
	modport sink(input valid, payload_offset, status, mapped_pages, output ready);
endinterface

// ----- rtl/core/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with coalescing over a 64-entry chunk table.
// ----------------------------------------------------------------------------
// One request is handled at a time. The table sits in a single-port-write,
// registered-read memory, so each entry visited is first read, then checked.
// A request scans entries in address order up to its hit. A split insert or
// a merge removal then shifts only the entries past the hit, reading and then
// writing each entry moved. The response is held in an output register, so
// the next request is taken while the previous response waits. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top import ffha_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffha_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (req.mode),
		.request_bytes  (req.request_bytes),
		.free_offset    (req.free_offset),
		.payload_offset (rsp.payload_offset),
		.status         (rsp.status),
		.mapped_pages   (rsp.mapped_pages)
	);

	// one request in flight
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");

	// error responses carry no offset
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.payload_offset == '0)
		else $error("offset on error response");

	// table never overflows
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		sts.cnt <= CNT_W'(CHUNKS))
		else $error("chunk count overflow");

endmodule

// ----- rtl/core/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: steps scan, merge, shift, append and response phases of each request.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_RESULT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_more) begin
					cmd.op  = OP_SCAN_RD;
					state_d = S_SCAN_CHK;
				end else if (sts.is_free) begin
					cmd.op  = OP_UNKNOWN;
					state_d = S_DONE;
				end else begin
					state_d = S_APPEND;
				end
			end
			S_SCAN_CHK: begin
				if (!sts.hit) begin
					cmd.op  = OP_SCAN_NEXT;
					state_d = S_SCAN_RD;
				end else if (sts.is_free) begin
					cmd.op  = OP_FREE_HIT;
					state_d = S_NEXT_RD;
				end else begin
					cmd.op  = OP_ALLOC_HIT;
					state_d = sts.split ? S_MOVE_RD : S_DONE;
				end
			end
			S_NEXT_RD: begin
				if (sts.has_next) begin
					cmd.op  = OP_NEXT_RD;
					state_d = S_NEXT_CHK;
				end else begin
					state_d = S_MERGE_L;
				end
			end
			S_NEXT_CHK: begin
				cmd.op  = OP_MERGE_R;
				state_d = S_MERGE_L;
			end
			S_MERGE_L: begin
				cmd.op  = OP_MERGE_L;
				state_d = S_FREE_FIN;
			end
			S_FREE_FIN: begin
				cmd.op  = OP_FREE_FIN;
				state_d = S_MOVE_RD;
			end
			S_APPEND: begin
				cmd.op  = OP_APPEND;
				state_d = S_DONE;
			end
			S_MOVE_RD: begin
				if (sts.move_more) begin
					cmd.op  = OP_MOVE_RD;
					state_d = S_MOVE_WR;
				end else begin
					state_d = S_MOVE_END;
				end
			end
			S_MOVE_WR: begin
				cmd.op  = OP_MOVE_WR;
				state_d = S_MOVE_RD;
			end
			S_MOVE_END: begin
				cmd.op  = OP_MOVE_END;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/ffha_dpath.sv -----
// ----------------------------------------------------------------------------
// ffha_dpath
// Chunk table memory, scan and merge registers, page accounting, response.
// ----------------------------------------------------------------------------
module ffha_dpath import ffha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              mode,
	input  logic [LEN_W-1:0]  request_bytes,
	input  logic [OFF_W-1:0]  free_offset,
	output logic [OFF_W-1:0]  payload_offset,
	output logic [1:0]        status,
	output logic [PAGE_W-1:0] mapped_pages
);

	entry_t mem [CHUNKS];
	entry_t rd_q, prev_q, cur_q, ins_q, wdata;
	logic   we, re;
	logic [IDX_W-1:0] waddr, raddr;

	logic              mode_q;
	logic [NEED_W-1:0] need_q;
	logic [OFF_W-1:0]  off_q;
	logic [CNT_W-1:0]  idx_q, count_q, mv_n_q;
	logic [LEN_W-1:0]  end_q;
	logic [IDX_W-1:0]  hit_q, j_q, src_q, dst_q;
	logic [1:0]        r_q;
	logic              mv_up_q;
	logic [OFF_W-1:0]  pay_q;
	logic [1:0]        stat_q;
	logic [PAGE_W-1:0] top_q;
	logic [OFF_W-1:0]  out_pay_q;
	logic [1:0]        out_stat_q;
	logic [PAGE_W-1:0] out_pages_q;

	logic              fit, split, match, exhausted, full, fin_last;
	logic [LEN_W-1:0]  left;
	logic [NEED_W:0]   app_sum;
	logic [CNT_W-1:0]  newcnt;
	logic [PAGE_W-1:0] app_pages, rel_pages;

	// compare and size terms
	always_comb begin
		fit       = rd_q.fr && ({1'b0, rd_q.len} >= need_q);
		left      = rd_q.len - need_q[LEN_W-1:0];
		full      = (count_q == CNT_W'(CHUNKS));
		split     = (left > LEN_W'(HEADER_BYTES)) && !full;
		match     = ({1'b0, rd_q.start} + (OFF_W+1)'(HEADER_BYTES)) == {1'b0, off_q};
		app_sum   = {2'b00, end_q} + {1'b0, need_q};
		exhausted = app_sum > (NEED_W+1)'(HEAP_BYTES);
		app_pages = pages_for(app_sum[LEN_W-1:0]);
		rel_pages = pages_for({1'b0, cur_q.start});
		newcnt    = count_q - CNT_W'(r_q);
		fin_last  = ({1'b0, j_q} + CNT_W'(1)) == newcnt;
	end

	// status to the sequencer
	always_comb begin
		sts.scan_more = idx_q < count_q;
		sts.is_free   = mode_q;
		sts.hit       = mode_q ? match : fit;
		sts.split     = split;
		sts.has_next  = ({1'b0, hit_q} + CNT_W'(1)) < count_q;
		sts.move_more = mv_n_q != '0;
		sts.cnt       = count_q;
	end

	// table read and write ports
	always_comb begin
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = rd_q;
		case (cmd.op)
			OP_SCAN_RD: begin
				re    = 1'b1;
				raddr = idx_q[IDX_W-1:0];
			end
			OP_NEXT_RD: begin
				re    = 1'b1;
				raddr = hit_q + IDX_W'(1);
			end
			OP_MOVE_RD: begin
				re    = 1'b1;
				raddr = src_q;
			end
			OP_ALLOC_HIT: begin
				we    = 1'b1;
				waddr = idx_q[IDX_W-1:0];
				wdata = '{start: rd_q.start,
					len: split ? need_q[LEN_W-1:0] : rd_q.len, fr: 1'b0};
			end
			OP_FREE_FIN: begin
				we    = !fin_last;
				waddr = j_q;
				wdata = cur_q;
			end
			OP_MOVE_WR: begin
				we    = 1'b1;
				waddr = dst_q;
				wdata = rd_q;
			end
			OP_MOVE_END: begin
				we    = !mode_q;
				waddr = hit_q + IDX_W'(1);
				wdata = ins_q;
			end
			OP_APPEND: begin
				we    = !exhausted && !full;
				waddr = count_q[IDX_W-1:0];
				wdata = '{start: end_q[OFF_W-1:0], len: need_q[LEN_W-1:0], fr: 1'b0};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// table size and mapped pages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			top_q   <= '0;
		end else begin
			case (cmd.op)
				OP_APPEND: begin
					if (!exhausted && !full) begin
						count_q <= count_q + CNT_W'(1);
						if (app_pages > top_q) begin
							top_q <= app_pages;
						end
					end
				end
				OP_MOVE_END: begin
					if (!mode_q) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_FREE_FIN: begin
					if (fin_last) begin
						count_q <= newcnt - CNT_W'(1);
						if (rel_pages < top_q) begin
							top_q <= rel_pages;
						end
					end else begin
						count_q <= newcnt;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// request, scan, merge and shift registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q <= mode;
				need_q <= {1'b0, request_bytes} + NEED_W'(HEADER_BYTES);
				off_q  <= free_offset;
				idx_q  <= '0;
				end_q  <= '0;
				mv_n_q <= '0;
				pay_q  <= '0;
				stat_q <= ST_OK;
			end
			OP_SCAN_NEXT: begin
				idx_q  <= idx_q + CNT_W'(1);
				end_q  <= {1'b0, rd_q.start} + rd_q.len;
				prev_q <= rd_q;
			end
			OP_ALLOC_HIT: begin
				hit_q   <= idx_q[IDX_W-1:0];
				pay_q   <= rd_q.start + OFF_W'(HEADER_BYTES);
				ins_q   <= '{start: rd_q.start + need_q[OFF_W-1:0], len: left, fr: 1'b1};
				src_q   <= count_q[IDX_W-1:0] - IDX_W'(1);
				dst_q   <= count_q[IDX_W-1:0];
				mv_n_q  <= count_q - CNT_W'(1) - idx_q;
				mv_up_q <= 1'b0;
			end
			OP_FREE_HIT: begin
				hit_q <= idx_q[IDX_W-1:0];
				j_q   <= idx_q[IDX_W-1:0];
				cur_q <= '{start: rd_q.start, len: rd_q.len, fr: 1'b1};
				r_q   <= 2'd0;
			end
			OP_MERGE_R: begin
				if (rd_q.fr) begin
					cur_q.len <= cur_q.len + rd_q.len;
					r_q       <= 2'd1;
				end
			end
			OP_MERGE_L: begin
				if (hit_q != '0 && prev_q.fr) begin
					cur_q <= '{start: prev_q.start, len: prev_q.len + cur_q.len, fr: 1'b1};
					j_q   <= hit_q - IDX_W'(1);
					r_q   <= r_q + 2'd1;
				end
			end
			OP_FREE_FIN: begin
				src_q   <= j_q + IDX_W'(1) + IDX_W'(r_q);
				dst_q   <= j_q + IDX_W'(1);
				mv_up_q <= 1'b1;
				mv_n_q  <= (fin_last || r_q == 2'd0) ? '0
					: newcnt - CNT_W'(1) - {1'b0, j_q};
			end
			OP_MOVE_WR: begin
				src_q  <= mv_up_q ? src_q + IDX_W'(1) : src_q - IDX_W'(1);
				dst_q  <= mv_up_q ? dst_q + IDX_W'(1) : dst_q - IDX_W'(1);
				mv_n_q <= mv_n_q - CNT_W'(1);
			end
			OP_APPEND: begin
				if (exhausted) begin
					stat_q <= ST_EXHAUSTED;
				end else if (full) begin
					stat_q <= ST_FULL;
				end else begin
					pay_q <= end_q[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
				end
			end
			OP_UNKNOWN: begin
				stat_q <= ST_UNKNOWN;
			end
			OP_RESULT: begin
				out_pay_q   <= pay_q;
				out_stat_q  <= stat_q;
				out_pages_q <= top_q;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign payload_offset = out_pay_q;
	assign status         = out_stat_q;
	assign mapped_pages   = out_pages_q;

endmodule
